// ===== rtl/core/wrsc_pkg.sv =====
// shared widths and codes for the window rectangle screen constrain block
package wrsc_pkg;

    localparam int OP_W     = 1;
    localparam int ENTRY_W  = 3;
    localparam int STATUS_W = 2;
    localparam int MINW_W   = 15;
    localparam int RIU_W    = 4;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int MAXR_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 1'b0,
        OP_PLACE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_REQ   = 2'd1,
        ST_NO_REGION = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_MIN_W   = 2'd0,
        REG_MIN_H   = 2'd1,
        REG_REGIONS = 2'd2
    } t_reg_idx;

endpackage

// ===== rtl/core/window_rect_screen_constrain.sv =====
// A write word (tuser 0) stores one region rectangle in the table; a
// place word (tuser 1) is clamped to the region it overlaps most, or to the nearest one.
// The table sits in one synchronous memory with one read port, and a place word sweeps
// it through a read, overlap, multiply and compare pipeline, with a second distance sweep
// when it overlaps no region; a rejected request, or one made while no regions are in
// use, skips the sweep and goes straight to the output register.
// Table entries reset to zero through one valid bit per entry, so no clearing pass runs.
// New words are taken as soon as the previous one has reached the output register.
module window_rect_screen_constrain #(
    parameter int MAX_REGIONS = 8,
    parameter int COORD_BITS  = 16,
    localparam int S_DATA_W = ((wrsc_pkg::ENTRY_W + 4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((4 * COORD_BITS + wrsc_pkg::ENTRY_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_index, rect_x, rect_y, rect_width, rect_height
    input  logic [S_DATA_W-1:0]            s_axis_tdata,
    // operation
    input  logic [wrsc_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x, out_y, out_width, out_height, chosen_region
    output logic [M_DATA_W-1:0]            m_axis_tdata,
    // status
    output logic [wrsc_pkg::STATUS_W-1:0]  m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wrsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [wrsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [wrsc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import wrsc_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int E     = CB + 2;
    localparam int OPW   = CB + 1;
    localparam int PW    = 2 * OPW;
    localparam int DW    = PW + 1;
    localparam int RW    = 4 * CB;
    localparam int IW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int WW    = ((CB > MINW_W) ? CB : MINW_W) + 1;
    localparam int M_PAD = M_DATA_W - RW - ENTRY_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SWEEP  = 6'b000010,
        S_CENTER = 6'b000100,
        S_CLAMP1 = 6'b001000,
        S_CLAMP2 = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    logic signed [E-1:0] one_e;
    logic signed [E-1:0] zero_e;
    assign one_e  = E'(1);
    assign zero_e = '0;

    // control
    t_state                r_state, n_state;
    logic [MAX_REGIONS-1:0] r_valid;
    logic                  r_mem_vq;
    logic                  r_s0_v, r_s1_v, r_s2_v;
    logic [CW-1:0]         r_cnt, r_n;
    logic                  r_pass2, r_found, r_have;
    logic                  r_m_v;
    logic [MINW_W-1:0]     r_min_w, r_min_h;
    logic [RIU_W-1:0]      r_riu;

    // payload
    logic [RW-1:0]         r_mem [MAX_REGIONS];
    logic [RW-1:0]         r_mem_q;
    logic [IW-1:0]         r_s0_idx, r_s1_idx, r_s2_idx;
    logic [RW-1:0]         r_s1_rect, r_s2_rect;
    logic [OPW-1:0]        r_s1_a, r_s1_b;
    logic [PW-1:0]         r_s2_p0, r_s2_p1;
    logic [DW-1:0]         r_best_val;
    logic [IW-1:0]         r_best_idx;
    logic [RW-1:0]         r_best_rect;
    logic signed [CB-1:0]  r_qx, r_qy, r_qw, r_qh;
    logic signed [E-1:0]   r_q_right, r_q_bottom;
    logic signed [E-1:0]   r_cx, r_cy;
    logic signed [CB-1:0]  r_cw, r_ch;
    logic signed [CB-1:0]  r_res_x, r_res_y, r_res_w, r_res_h;
    logic [ENTRY_W-1:0]    r_res_idx;
    t_status               r_res_st;
    logic [M_DATA_W-1:0]   r_m_data;
    logic [STATUS_W-1:0]   r_m_user;

    // input word
    logic                  in_acc, in_place, in_bad, wr_ok, mem_we;
    logic [ENTRY_W-1:0]    in_entry;
    logic [RW-1:0]         in_rect;
    logic signed [CB-1:0]  in_x, in_y, in_w, in_h;
    logic [MAXR_W-1:0]     slot_ext, riu_ext, n_sat;
    logic [IW-1:0]         wr_addr;
    logic [CW-1:0]         in_n;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_place = (t_op'(s_axis_tuser) == OP_PLACE);
    assign in_entry = s_axis_tdata[ENTRY_W-1:0];
    assign in_rect  = s_axis_tdata[ENTRY_W +: RW];
    assign in_x     = $signed(in_rect[0 +: CB]);
    assign in_y     = $signed(in_rect[CB +: CB]);
    assign in_w     = $signed(in_rect[2*CB +: CB]);
    assign in_h     = $signed(in_rect[3*CB +: CB]);
    assign in_bad   = in_w[CB-1] || (in_w == '0) || in_h[CB-1] || (in_h == '0);
    assign slot_ext = MAXR_W'(in_entry);
    assign wr_ok    = (slot_ext < MAXR_W'(MAX_REGIONS));
    assign wr_addr  = slot_ext[IW-1:0];
    assign mem_we   = in_acc && !in_place && wr_ok;
    assign riu_ext  = MAXR_W'(r_riu);
    assign n_sat    = (riu_ext > MAXR_W'(MAX_REGIONS)) ? MAXR_W'(MAX_REGIONS) : riu_ext;
    assign in_n     = n_sat[CW-1:0];

    // table sweep
    logic           rd_en, sweep_done;
    logic [IW-1:0]  rd_addr;

    assign rd_en      = (r_state == S_SWEEP) && (r_cnt < r_n);
    assign rd_addr    = r_cnt[IW-1:0];
    assign sweep_done = (r_state == S_SWEEP) && (r_cnt == r_n) && !r_s0_v && !r_s1_v
                        && !r_s2_v;

    // stage 1: overlap extents or gaps
    logic [RW-1:0]         s1_rect;
    logic signed [CB-1:0]  ex, ey, ew, eh;
    logic signed [E-1:0]   ex_e, ey_e, er, eb, qx_e, qy_e;
    logic signed [E-1:0]   ov_l, ov_r, ov_t, ov_b, ov_w, ov_h, gap_x, gap_y;
    logic                  ov_hit;
    logic [OPW-1:0]        s1_a, s1_b;

    assign s1_rect = r_mem_vq ? r_mem_q : '0;
    assign ex   = $signed(s1_rect[0 +: CB]);
    assign ey   = $signed(s1_rect[CB +: CB]);
    assign ew   = $signed(s1_rect[2*CB +: CB]);
    assign eh   = $signed(s1_rect[3*CB +: CB]);
    assign ex_e = E'(ex);
    assign ey_e = E'(ey);
    assign er   = ex_e + E'(ew) - one_e;
    assign eb   = ey_e + E'(eh) - one_e;
    assign qx_e = E'(r_qx);
    assign qy_e = E'(r_qy);

    assign ov_l   = (qx_e > ex_e) ? qx_e : ex_e;
    assign ov_r   = (r_q_right < er) ? r_q_right : er;
    assign ov_t   = (qy_e > ey_e) ? qy_e : ey_e;
    assign ov_b   = (r_q_bottom < eb) ? r_q_bottom : eb;
    assign ov_w   = ov_r - ov_l + one_e;
    assign ov_h   = ov_b - ov_t + one_e;
    assign ov_hit = (ov_l <= ov_r) && (ov_t <= ov_b);

    assign gap_x = (r_cx < ex_e) ? (ex_e - r_cx) : ((r_cx > er) ? (r_cx - er) : zero_e);
    assign gap_y = (r_cy < ey_e) ? (ey_e - r_cy) : ((r_cy > eb) ? (r_cy - eb) : zero_e);

    assign s1_a = r_pass2 ? gap_x[OPW-1:0] : (ov_hit ? ov_w[OPW-1:0] : '0);
    assign s1_b = r_pass2 ? gap_y[OPW-1:0] : (ov_hit ? ov_h[OPW-1:0] : '0);

    // stage 2: area or squared gaps
    logic [OPW-1:0] mul_b;
    logic [PW-1:0]  m0, m1;

    assign mul_b = r_pass2 ? r_s1_a : r_s1_b;
    assign m0    = PW'(r_s1_a) * PW'(mul_b);
    assign m1    = PW'(r_s1_b) * PW'(r_s1_b);

    // stage 3: best so far
    logic [DW-1:0] s3_val;
    logic          upd;

    assign s3_val = r_pass2 ? (DW'(r_s2_p0) + DW'(r_s2_p1)) : DW'(r_s2_p0);
    assign upd    = r_s2_v && (r_pass2 ? (!r_have || (s3_val < r_best_val))
                                       : (s3_val > r_best_val));

    // centre of the request, truncated toward zero
    logic signed [E-1:0] cs_x, cs_y, cr_x, cr_y;

    assign cs_x = qx_e + r_q_right;
    assign cs_y = qy_e + r_q_bottom;
    assign cr_x = cs_x + (cs_x[E-1] ? one_e : zero_e);
    assign cr_y = cs_y + (cs_y[E-1] ? one_e : zero_e);

    // clamp against the chosen region
    logic signed [CB-1:0] bx, by, bw, bh;
    logic signed [E-1:0]  bx_e, by_e, hi_x, hi_y, lo_x, lo_y, fx, fy;
    logic signed [WW-1:0] gw, gh, lw, lh;
    logic                 best_ok;
    logic [MAXR_W-1:0]    best_ext;

    assign bx      = $signed(r_best_rect[0 +: CB]);
    assign by      = $signed(r_best_rect[CB +: CB]);
    assign bw      = $signed(r_best_rect[2*CB +: CB]);
    assign bh      = $signed(r_best_rect[3*CB +: CB]);
    assign best_ok = !bw[CB-1] && (bw != '0) && !bh[CB-1] && (bh != '0);
    assign gw = (WW'(r_qw) > WW'($signed({1'b0, r_min_w}))) ? WW'(r_qw)
                                                           : WW'($signed({1'b0, r_min_w}));
    assign gh = (WW'(r_qh) > WW'($signed({1'b0, r_min_h}))) ? WW'(r_qh)
                                                           : WW'($signed({1'b0, r_min_h}));
    assign lw = (gw < WW'(bw)) ? gw : WW'(bw);
    assign lh = (gh < WW'(bh)) ? gh : WW'(bh);

    assign bx_e = E'(bx);
    assign by_e = E'(by);
    assign hi_x = bx_e + E'(bw) - E'(r_cw);
    assign hi_y = by_e + E'(bh) - E'(r_ch);
    assign lo_x = (qx_e < hi_x) ? qx_e : hi_x;
    assign lo_y = (qy_e < hi_y) ? qy_e : hi_y;
    assign fx   = (bx_e > lo_x) ? bx_e : lo_x;
    assign fy   = (by_e > lo_y) ? by_e : lo_y;
    assign best_ext = MAXR_W'(r_best_idx);

    logic out_load;
    assign out_load = (r_state == S_EMIT) && (!r_m_v || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && in_place) begin
                    n_state = (in_bad || (in_n == '0)) ? S_EMIT : S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (sweep_done) begin
                    n_state = (!r_pass2 && !r_found) ? S_CENTER : S_CLAMP1;
                end
            end
            S_CENTER: n_state = S_SWEEP;
            S_CLAMP1: n_state = best_ok ? S_CLAMP2 : S_EMIT;
            S_CLAMP2: n_state = S_EMIT;
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_mem_vq <= 1'b0;
            r_s0_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_cnt    <= '0;
            r_n      <= '0;
            r_pass2  <= 1'b0;
            r_found  <= 1'b0;
            r_have   <= 1'b0;
            r_m_v    <= 1'b0;
            r_min_w  <= '0;
            r_min_h  <= '0;
            r_riu    <= '0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_mem_vq <= r_valid[rd_addr];
                r_cnt    <= r_cnt + CW'(1);
            end
            r_s0_v <= rd_en;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            if (in_acc && in_place) begin
                r_cnt   <= '0;
                r_n     <= in_n;
                r_pass2 <= 1'b0;
                r_found <= 1'b0;
                r_have  <= 1'b0;
            end
            if (r_state == S_CENTER) begin
                r_cnt   <= '0;
                r_pass2 <= 1'b1;
                r_have  <= 1'b0;
            end
            if (upd) begin
                r_have <= 1'b1;
                if (!r_pass2) begin
                    r_found <= 1'b1;
                end
            end
            if (out_load) begin
                r_m_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_v <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_MIN_W:   r_min_w <= pwdata[MINW_W-1:0];
                    REG_MIN_H:   r_min_h <= pwdata[MINW_W-1:0];
                    REG_REGIONS: r_riu   <= pwdata[RIU_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // region table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= in_rect;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s0_idx  <= rd_addr;
        r_s1_idx  <= r_s0_idx;
        r_s1_rect <= s1_rect;
        r_s1_a    <= s1_a;
        r_s1_b    <= s1_b;
        r_s2_idx  <= r_s1_idx;
        r_s2_rect <= r_s1_rect;
        r_s2_p0   <= m0;
        r_s2_p1   <= m1;

        if (in_acc && in_place) begin
            r_qx        <= in_x;
            r_qy        <= in_y;
            r_qw        <= in_w;
            r_qh        <= in_h;
            r_q_right   <= E'(in_x) + E'(in_w) - one_e;
            r_q_bottom  <= E'(in_y) + E'(in_h) - one_e;
            r_best_val  <= '0;
            r_best_idx  <= '0;
            r_best_rect <= '0;
            r_res_x     <= in_x;
            r_res_y     <= in_y;
            r_res_w     <= in_w;
            r_res_h     <= in_h;
            r_res_idx   <= '0;
            r_res_st    <= in_bad ? ST_BAD_REQ : ST_NO_REGION;
        end
        if (upd) begin
            r_best_val  <= s3_val;
            r_best_idx  <= r_s2_idx;
            r_best_rect <= r_s2_rect;
        end
        if (r_state == S_CENTER) begin
            r_cx <= cr_x >>> 1;
            r_cy <= cr_y >>> 1;
        end
        if (r_state == S_CLAMP1) begin
            r_cw <= lw[CB-1:0];
            r_ch <= lh[CB-1:0];
        end
        if (r_state == S_CLAMP2) begin
            r_res_x   <= fx[CB-1:0];
            r_res_y   <= fy[CB-1:0];
            r_res_w   <= r_cw;
            r_res_h   <= r_ch;
            r_res_idx <= best_ext[ENTRY_W-1:0];
            r_res_st  <= ST_OK;
        end
        if (out_load) begin
            r_m_data <= {{M_PAD{1'b0}}, r_res_idx, r_res_h, r_res_w, r_res_y, r_res_x};
            r_m_user <= r_res_st;
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_MIN_W:   prdata = PDATA_W'(r_min_w);
            REG_MIN_H:   prdata = PDATA_W'(r_min_h);
            REG_REGIONS: prdata = PDATA_W'(r_riu);
            default:     prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_m_v;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== rtl/core/wrsc_checker.sv =====
// port level checks for the window rectangle screen constrain block
module wrsc_checker #(
    parameter int COORD_BITS = 16,
    localparam int M_DATA_W = ((4 * COORD_BITS + wrsc_pkg::ENTRY_W + 7) / 8) * 8
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    // operation
    input logic [wrsc_pkg::OP_W-1:0]      s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    // out_x, out_y, out_width, out_height, chosen_region
    input logic [M_DATA_W-1:0]            m_axis_tdata,
    // status
    input logic [wrsc_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import wrsc_pkg::*;

    localparam int CB = COORD_BITS;

    logic [CB-1:0]      o_w, o_h;
    logic [ENTRY_W-1:0] o_idx;

    assign o_w   = m_axis_tdata[2*CB +: CB];
    assign o_h   = m_axis_tdata[3*CB +: CB];
    assign o_idx = m_axis_tdata[4*CB +: ENTRY_W];

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a place word keeps the input closed while it sweeps
    a_place_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PLACE) |=> !s_axis_tready)
        else $error("input open right after a place word");

    // passed-through words report region zero
    a_pass_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (o_idx == '0))
        else $error("region index set on a passed-through word");

    // constrained words have a positive size
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) |->
            !o_w[CB-1] && (o_w != '0) && !o_h[CB-1] && (o_h != '0))
        else $error("constrained word with empty size");

endmodule

bind window_rect_screen_constrain wrsc_checker #(.COORD_BITS(COORD_BITS)) u_wrsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_window_rect_screen_constrain.sv =====
// testbench for window_rect_screen_constrain: region table writes and clamped placements checked against a predictor
`timescale 1ns / 1ps

module tb_window_rect_screen_constrain;
    import wrsc_pkg::*;

    localparam int SETTLE   = 40;
    localparam int N_PHASES = 8;
    localparam int PHASE_N  = 70;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } rect_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [2:0]         chosen;
        t_status            status;
    } placed_t;

    class placement_scoreboard;
        rect_t       regions[8];
        longint      min_w;
        longint      min_h;
        longint      used;
        placed_t     pending[$];
        int unsigned errors;

        function new();
            foreach (regions[i]) regions[i] = '0;
            min_w  = 0;
            min_h  = 0;
            used   = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_MIN_W:   min_w = val & 32'h7fff;
                REG_MIN_H:   min_h = val & 32'h7fff;
                REG_REGIONS: used  = val & 32'hf;
                default: ;
            endcase
        endfunction

        function placed_t clamp_to_region(rect_t r);
            placed_t p;
            longint  qx, qy, qw, qh, gx, gy, gw, gh;
            longint  lo, hi, top, bot, area, best_val, cx, cy, dx, dy, d, w, h, x, y;
            int      n, best;
            bit      hit;
            qx = r.x;
            qy = r.y;
            qw = r.w;
            qh = r.h;
            p.x = r.x;
            p.y = r.y;
            p.w = r.w;
            p.h = r.h;
            p.chosen = '0;
            p.status = ST_BAD_REQ;
            if (qw <= 0 || qh <= 0) return p;
            p.status = ST_NO_REGION;
            n = (used > 8) ? 8 : int'(used);
            if (n == 0) return p;
            best = 0;
            best_val = 0;
            hit = 1'b0;
            // largest overlap, first strictly larger wins
            for (int i = 0; i < n; i++) begin
                gx = regions[i].x;
                gy = regions[i].y;
                gw = regions[i].w;
                gh = regions[i].h;
                lo  = (qx > gx) ? qx : gx;
                hi  = (qx + qw - 1 < gx + gw - 1) ? qx + qw - 1 : gx + gw - 1;
                top = (qy > gy) ? qy : gy;
                bot = (qy + qh - 1 < gy + gh - 1) ? qy + qh - 1 : gy + gh - 1;
                area = (lo > hi || top > bot) ? 0 : (hi - lo + 1) * (bot - top + 1);
                if (area > best_val) begin
                    best_val = area;
                    best = i;
                    hit = 1'b1;
                end
            end
            // nearest by squared distance from the truncated centre
            if (!hit) begin
                cx = (qx + qx + qw - 1) / 2;
                cy = (qy + qy + qh - 1) / 2;
                best_val = 64'h7fff_ffff_ffff_ffff;
                for (int i = 0; i < n; i++) begin
                    gx = regions[i].x;
                    gy = regions[i].y;
                    gw = regions[i].w;
                    gh = regions[i].h;
                    dx = (cx < gx) ? gx - cx : (cx > gx + gw - 1) ? cx - (gx + gw - 1) : 0;
                    dy = (cy < gy) ? gy - cy : (cy > gy + gh - 1) ? cy - (gy + gh - 1) : 0;
                    d = dx * dx + dy * dy;
                    if (d < best_val) begin
                        best_val = d;
                        best = i;
                    end
                end
            end
            gx = regions[best].x;
            gy = regions[best].y;
            gw = regions[best].w;
            gh = regions[best].h;
            if (gw <= 0 || gh <= 0) return p;
            w = (qw > min_w) ? qw : min_w;
            h = (qh > min_h) ? qh : min_h;
            w = (w < gw) ? w : gw;
            h = (h < gh) ? h : gh;
            x = (qx < gx + gw - w) ? qx : gx + gw - w;
            x = (x > gx) ? x : gx;
            y = (qy < gy + gh - h) ? qy : gy + gh - h;
            y = (y > gy) ? y : gy;
            p.x = x[15:0];
            p.y = y[15:0];
            p.w = w[15:0];
            p.h = h[15:0];
            p.chosen = best[2:0];
            p.status = ST_OK;
            return p;
        endfunction

        function void note_word(t_op op, logic [2:0] slot, rect_t r);
            if (op == OP_WRITE) regions[slot] = r;
            else pending.push_back(clamp_to_region(r));
        endfunction

        function void check_result(logic [71:0] d, logic [1:0] u);
            placed_t got, want;
            got.x = d[15:0];
            got.y = d[31:16];
            got.w = d[47:32];
            got.h = d[63:48];
            got.chosen = d[66:64];
            got.status = t_status'(u);
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: x=%0d y=%0d w=%0d h=%0d region=%0d status=%0d",
                             got.x, got.y, got.w, got.h, got.chosen, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.w !== want.w || got.h !== want.h ||
                got.chosen !== want.chosen || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected x=%0d y=%0d w=%0d h=%0d region=%0d status=%0d, got x=%0d y=%0d w=%0d h=%0d region=%0d status=%0d",
                             want.x, want.y, want.w, want.h, want.chosen, want.status,
                             got.x, got.y, got.w, got.h, got.chosen, got.status);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // entry_index, rect_x, rect_y, rect_width, rect_height
    logic [71:0]         s_axis_tdata = '0;
    // operation
    logic [OP_W-1:0]     s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // out_x, out_y, out_width, out_height, chosen_region
    logic [71:0]         m_axis_tdata;
    // status
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    placement_scoreboard sb = new();
    int tx_pct = 0;
    int rx_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    window_rect_screen_constrain i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // result side: check accepted words, then stall at random or for a long hold
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (int'($urandom_range(99)) >= rx_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("tb_window_rect_screen_constrain failed");
        $finish;
    end

    function automatic logic signed [15:0] sat16(int v);
        if (v < -32768) return 16'sh8000;
        if (v > 32767) return 16'sh7fff;
        return 16'(v);
    endfunction

    function automatic rect_t mk(int x, int y, int w, int h);
        rect_t r;
        r.x = 16'(x);
        r.y = 16'(y);
        r.w = 16'(w);
        r.h = 16'(h);
        return r;
    endfunction

    function automatic rect_t rand_region();
        rect_t g;
        int    k;
        k = $urandom_range(99);
        if (k < 75) begin
            g = mk(int'($urandom_range(8000)) - 4000, int'($urandom_range(8000)) - 4000,
                   $urandom_range(4000, 1), $urandom_range(4000, 1));
        end else if (k < 90) begin
            g = mk($urandom, $urandom, $urandom, $urandom);
        end else begin
            g = mk(int'($urandom_range(8000)) - 4000, int'($urandom_range(8000)) - 4000,
                   -int'($urandom_range(32768)), $urandom_range(4000, 1));
            if (k[0]) g = mk(g.x, g.y, g.h, g.w);
        end
        return g;
    endfunction

    function automatic rect_t rand_request();
        rect_t g, r;
        int    k, span_x, span_y;
        k = $urandom_range(99);
        if (k < 60) begin
            g = sb.regions[$urandom_range(7)];
            span_x = (g.w > 0 && g.w < 8000) ? int'(g.w) : 2000;
            span_y = (g.h > 0 && g.h < 8000) ? int'(g.h) : 2000;
            r.x = sat16(int'(g.x) + int'($urandom_range(2 * span_x)) - span_x);
            r.y = sat16(int'(g.y) + int'($urandom_range(2 * span_y)) - span_y);
            r.w = ($urandom_range(9) == 0) ? 16'sh7fff : sat16($urandom_range(3000, 1));
            r.h = ($urandom_range(9) == 0) ? 16'sh7fff : sat16($urandom_range(3000, 1));
        end else if (k < 80) begin
            r = mk(int'($urandom_range(60000)) - 30000, int'($urandom_range(60000)) - 30000,
                   $urandom_range(500, 1), $urandom_range(500, 1));
        end else if (k < 92) begin
            r = mk($urandom, $urandom, $urandom, $urandom);
        end else begin
            r = mk($urandom, $urandom, -int'($urandom_range(32768)), $urandom_range(3000, 1));
            if (k[0]) r = mk(r.x, r.y, r.h, r.w);
        end
        return r;
    endfunction

    task automatic send_word(t_op op, logic [2:0] slot, rect_t r);
        while (int'($urandom_range(99)) < tx_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, r.h, r.w, r.y, r.x, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, slot, r);
    endtask

    task automatic apb_xfer(bit wr, t_reg_idx idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        logic [31:0] rd, mask;
        mask = (idx == REG_REGIONS) ? 32'hf : 32'h7fff;
        apb_xfer(1'b1, idx, val, rd);
        sb.set_reg(idx, val);
        apb_xfer(1'b0, idx, '0, rd);
        if ((rd & mask) !== (val & mask)) begin
            sb.errors++;
            if (sb.errors <= 10)
                $display("register %0d readback: expected %0h, got %0h", idx, val & mask, rd);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int mode;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table and rejected requests
        send_word(OP_PLACE, 3'd0, mk(10, 10, 100, 100));
        send_word(OP_PLACE, 3'd7, mk(-32768, 32767, 0, 5));
        send_word(OP_PLACE, 3'd0, mk(0, 0, 5, -32768));
        send_word(OP_PLACE, 3'd0, mk(0, 0, -1, -1));
        settle();
        write_reg(REG_REGIONS, 2);
        // regions still zero, distance pass lands on an invalid region
        send_word(OP_PLACE, 3'd0, mk(100, 100, 50, 50));

        send_word(OP_WRITE, 3'd0, mk(0, 0, 1920, 1080));
        send_word(OP_WRITE, 3'd1, mk(1920, 0, 1280, 1024));
        send_word(OP_WRITE, 3'd2, mk(1920, 0, 1280, 1024));
        send_word(OP_WRITE, 3'd3, mk(-32768, -32768, 32767, 32767));
        send_word(OP_WRITE, 3'd4, mk(32767, 32767, 32767, 32767));
        send_word(OP_WRITE, 3'd5, mk(-1000, 2000, 800, 600));
        send_word(OP_WRITE, 3'd6, mk(100, 100, -5, 10));
        send_word(OP_WRITE, 3'd7, mk(5000, 5000, 1, 1));
        settle();
        write_reg(REG_REGIONS, 8);
        send_word(OP_PLACE, 3'd0, mk(1800, 100, 400, 300));
        send_word(OP_PLACE, 3'd0, mk(2000, 100, 100, 100));
        send_word(OP_PLACE, 3'd0, mk(3500, 100, 10, 10));
        send_word(OP_PLACE, 3'd0, mk(-500, -500, 5000, 5000));
        send_word(OP_PLACE, 3'd0, mk(-32768, -32768, 1, 1));
        send_word(OP_PLACE, 3'd0, mk(32767, 32767, 32767, 32767));
        send_word(OP_PLACE, 3'd0, mk(-20001, 20001, 2, 2));
        send_word(OP_PLACE, 3'd0, mk(5000, 5000, 1, 1));
        send_word(OP_PLACE, 3'd0, mk(100, 100, 3, 3));
        settle();
        write_reg(REG_MIN_W, 32767);
        write_reg(REG_MIN_H, 32767);
        send_word(OP_PLACE, 3'd0, mk(10, 10, 5, 5));
        send_word(OP_PLACE, 3'd0, mk(-990, 2010, 1, 1));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin write_reg(REG_MIN_W, 0); write_reg(REG_MIN_H, 0);
                    write_reg(REG_REGIONS, 8); end
                1: begin write_reg(REG_MIN_W, 32767); write_reg(REG_MIN_H, 32767); end
                2: begin write_reg(REG_MIN_W, 640); write_reg(REG_MIN_H, 480);
                    write_reg(REG_REGIONS, 4); end
                3: begin write_reg(REG_MIN_W, 0); write_reg(REG_MIN_H, 0);
                    write_reg(REG_REGIONS, 15); end
                5: begin write_reg(REG_MIN_W, 1); write_reg(REG_MIN_H, 1);
                    write_reg(REG_REGIONS, 1); end
                6: begin write_reg(REG_MIN_W, 0); write_reg(REG_MIN_H, 32767);
                    write_reg(REG_REGIONS, 2); end
                default: begin
                    write_reg(REG_MIN_W, $urandom_range(32767));
                    write_reg(REG_MIN_H, $urandom_range(32767));
                    write_reg(REG_REGIONS, (ph == 7) ? 8 : $urandom_range(15));
                end
            endcase
            mode = ph % 4;
            tx_pct = (mode == 1) ? 59 : (mode == 3) ? 14 : 0;
            rx_pct = (mode == 2) ? 59 : (mode == 3) ? 14 : 0;
            for (int k = 0; k < PHASE_N; k++) begin
                if (ph == 0 && k == 10) hold_req = 300;
                if (k == PHASE_N / 2) settle();
                if ($urandom_range(3) == 0)
                    send_word(OP_WRITE, 3'($urandom), rand_region());
                else
                    send_word(OP_PLACE, 3'($urandom), rand_request());
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_window_rect_screen_constrain passed");
        end else begin
            $display("tb_window_rect_screen_constrain failed");
        end
        $finish;
    end

endmodule
